### sv/tlg_pkg.sv
`default_nettype none

package tlg_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_STEP  = 2'd3
    } t_func;

    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int FIELD_W       = 6;
    localparam int COUNT_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam int DIM_MIN   = 3;
    localparam int DIM_RESET = 64;

    localparam int LIFE_BIRTH   = 3;
    localparam int LIFE_SURVIVE = 2;

endpackage

`default_nettype wire

### sv/tlg_cell_mem.sv
`default_nettype none

module tlg_cell_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/tlg_col_rule.sv
`default_nettype none

module tlg_col_rule #(
    parameter int MAX_ROWS = 64
) (
    input  wire  [MAX_ROWS-1:0]            i_left,
    input  wire  [MAX_ROWS-1:0]            i_mid,
    input  wire  [MAX_ROWS-1:0]            i_right,
    input  wire  [$clog2(MAX_ROWS+1)-1:0]  i_height,
    output logic [MAX_ROWS-1:0]            o_next
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int HW = $clog2(MAX_ROWS+1);
    localparam int CNTW = tlg_pkg::COUNT_W;

    logic [RW-1:0] w_last;
    logic          w_lt, w_mt, w_rt;

    assign w_last = RW'(i_height - HW'(1));
    assign w_lt   = i_left[w_last];
    assign w_mt   = i_mid[w_last];
    assign w_rt   = i_right[w_last];

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
        localparam int UP = (g == 0) ? 0 : g - 1;
        localparam int DN = (g == MAX_ROWS - 1) ? 0 : g + 1;

        logic            w_ul, w_um, w_ur, w_dl, w_dm, w_dr, w_wrap_dn;
        logic [CNTW-1:0] w_cnt;
        logic            w_rule;

        assign w_ul = (g == 0) ? w_lt : i_left[UP];
        assign w_um = (g == 0) ? w_mt : i_mid[UP];
        assign w_ur = (g == 0) ? w_rt : i_right[UP];

        assign w_wrap_dn = (w_last == RW'(g));
        assign w_dl = w_wrap_dn ? i_left[0]  : i_left[DN];
        assign w_dm = w_wrap_dn ? i_mid[0]   : i_mid[DN];
        assign w_dr = w_wrap_dn ? i_right[0] : i_right[DN];

        assign w_cnt = CNTW'(w_ul) + CNTW'(w_um) + CNTW'(w_ur)
                     + CNTW'(i_left[g]) + CNTW'(i_right[g])
                     + CNTW'(w_dl) + CNTW'(w_dm) + CNTW'(w_dr);

        assign w_rule = (w_cnt == CNTW'(tlg_pkg::LIFE_BIRTH))
                      || (i_mid[g] && (w_cnt == CNTW'(tlg_pkg::LIFE_SURVIVE)));

        assign o_next[g] = (HW'(g) < i_height) ? w_rule : i_mid[g];
    end

endmodule

`default_nettype wire

### sv/toroidal_life_grid_engine.sv
`default_nettype none

// Channel   Handshake                  Payload
// request   i_in_valid / o_in_ready    i_func, i_col, i_row, i_cell_value
// result    o_out_valid / i_out_ready  o_read_value, o_done_op
// config    i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// Cell read or write: one column word is read, and a write writes it back modified.
// Clear: one column word per cycle. Advance: one pass over the column memory port.
// After reset a clearing pass over all MAX_COLS columns runs before the first request is taken.
// A waiting result does not block acceptance; the next result holds until it drains.

module toroidal_life_grid_engine #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [1:0]                   i_func,
    input  wire  [5:0]                   i_col,
    input  wire  [5:0]                   i_row,
    input  wire                          i_cell_value,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_read_value,
    output logic [1:0]                   o_done_op,
    input  wire                          i_cfg_we,
    input  wire  [tlg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [tlg_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int WW = $clog2(MAX_COLS + 1);
    localparam int SW = $clog2(MAX_COLS + 3);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int RST_W = (tlg_pkg::DIM_RESET > MAX_COLS) ? MAX_COLS : tlg_pkg::DIM_RESET;
    localparam int RST_H = (tlg_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS : tlg_pkg::DIM_RESET;

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_CLR  = 6'b001000,
        ST_GEN  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    tlg_pkg::t_func r_func;
    logic [5:0]     r_col, r_row;
    logic           r_val;
    logic [CW-1:0]  r_clr, n_clr;
    logic [SW-1:0]  r_step, n_step;
    logic [WW-1:0]  r_eff_w;
    logic [HW-1:0]  r_eff_h;
    logic           r_rd_bit, n_rd_bit;
    logic           r_out_valid, n_out_valid;
    logic           r_out_read, n_out_read;
    tlg_pkg::t_func r_out_op, n_out_op;
    logic [MAX_ROWS-1:0] r_left, r_mid, r_col0;

    logic                rd_en, wr_en;
    logic [CW-1:0]       rd_addr, wr_addr;
    logic [MAX_ROWS-1:0] wr_data, rd_data, rule_next, gen_right, cell_mask;
    logic                accept, in_grid, gen_last;

    function automatic tlg_pkg::t_func t_func_of(input logic [1:0] code);
        return tlg_pkg::t_func'(code);
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_grid    = (int'(r_col) < int'(r_eff_w)) && (int'(r_row) < int'(r_eff_h));
    assign gen_last   = (r_step == SW'(r_eff_w) + SW'(2));
    assign gen_right  = gen_last ? r_col0 : rd_data;
    assign cell_mask  = MAX_ROWS'(1) << RW'(r_row);

    tlg_cell_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (MAX_ROWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    tlg_col_rule #(
        .MAX_ROWS (MAX_ROWS)
    ) u_rule (
        .i_left   (r_left),
        .i_mid    (r_mid),
        .i_right  (gen_right),
        .i_height (r_eff_h),
        .o_next   (rule_next)
    );

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = CW'(i_col);
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        case (r_state)
            ST_IDLE: begin
                rd_en = accept && ((t_func_of(i_func) == tlg_pkg::FUNC_WRITE)
                                   || (t_func_of(i_func) == tlg_pkg::FUNC_READ));
            end
            ST_ACC: begin
                wr_en   = (r_func == tlg_pkg::FUNC_WRITE) && in_grid;
                wr_addr = CW'(r_col);
                wr_data = r_val ? (rd_data | cell_mask) : (rd_data & ~cell_mask);
            end
            ST_INIT, ST_CLR: begin
                wr_en = 1'b1;
            end
            ST_GEN: begin
                rd_en   = (r_step <= SW'(r_eff_w));
                rd_addr = (r_step == '0) ? CW'(r_eff_w - WW'(1)) : CW'(r_step - SW'(1));
                wr_en   = (r_step >= SW'(3));
                wr_addr = CW'(r_step - SW'(3));
                wr_data = rule_next;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_step      = r_step;
        n_rd_bit    = r_rd_bit;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_read  = r_out_read;
        n_out_op    = r_out_op;
        case (r_state)
            ST_INIT, ST_CLR: begin
                n_clr = r_clr + CW'(1);
                if (r_clr == CW'(MAX_COLS - 1)) begin
                    n_clr   = '0;
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_FIN;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_step   = '0;
                    n_clr    = '0;
                    n_rd_bit = 1'b0;
                    case (t_func_of(i_func))
                        tlg_pkg::FUNC_CLEAR: n_state = ST_CLR;
                        tlg_pkg::FUNC_STEP:  n_state = ST_GEN;
                        default:             n_state = ST_ACC;
                    endcase
                end
            end
            ST_ACC: begin
                n_rd_bit = in_grid && (r_func == tlg_pkg::FUNC_READ) && rd_data[RW'(r_row)];
                n_state  = ST_FIN;
            end
            ST_GEN: begin
                n_step = r_step + SW'(1);
                if (gen_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_read  = r_rd_bit;
                    n_out_op    = r_func;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_clr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_rd_bit    <= 1'b0;
            r_eff_w     <= WW'(RST_W);
            r_eff_h     <= HW'(RST_H);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_rd_bit    <= n_rd_bit;
            if (i_cfg_we && (i_cfg_index == tlg_pkg::CFG_GRID_WIDTH)) begin
                if (int'(i_cfg_wdata) < tlg_pkg::DIM_MIN) begin
                    r_eff_w <= WW'(tlg_pkg::DIM_MIN);
                end else if (int'(i_cfg_wdata) > MAX_COLS) begin
                    r_eff_w <= WW'(MAX_COLS);
                end else begin
                    r_eff_w <= WW'(i_cfg_wdata);
                end
            end
            if (i_cfg_we && (i_cfg_index == tlg_pkg::CFG_GRID_HEIGHT)) begin
                if (int'(i_cfg_wdata) < tlg_pkg::DIM_MIN) begin
                    r_eff_h <= HW'(tlg_pkg::DIM_MIN);
                end else if (int'(i_cfg_wdata) > MAX_ROWS) begin
                    r_eff_h <= HW'(MAX_ROWS);
                end else begin
                    r_eff_h <= HW'(i_cfg_wdata);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_read <= n_out_read;
        r_out_op   <= n_out_op;
        if (accept) begin
            r_func <= t_func_of(i_func);
            r_col  <= i_col;
            r_row  <= i_row;
            r_val  <= i_cell_value;
        end
        if (r_state == ST_GEN) begin
            r_left <= r_mid;
            r_mid  <= rd_data;
            if (r_step == SW'(2)) begin
                r_col0 <= rd_data;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_read;
    assign o_done_op    = r_out_op;

endmodule

`default_nettype wire

### dv/toroidal_life_grid_engine_tb.sv
`default_nettype none

module toroidal_life_grid_engine_tb;

    localparam int COLS        = 64;
    localparam int ROWS        = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = COLS + 16;
    localparam int SCRIPT_LEN  = 22;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 216;

    typedef struct packed {
        logic           rd;
        tlg_pkg::t_func op;
    } t_board_result;

    typedef struct packed {
        tlg_pkg::t_func op;
        logic [5:0]     col;
        logic [5:0]     row;
        logic           val;
        logic           typed;
        logic           rd;
    } t_script_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    tlg_pkg::t_func     in_func = tlg_pkg::FUNC_READ;
    logic [5:0]         in_col = '0;
    logic [5:0]         in_row = '0;
    logic               in_val = 1'b0;
    logic               out_ready = 1'b0;
    logic               cfg_we = 1'b0;
    logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index = tlg_pkg::CFG_GRID_WIDTH;
    logic [tlg_pkg::CFG_W-1:0]     cfg_wdata = '0;

    wire                o_in_ready;
    wire                o_out_valid;
    wire                o_read_value;
    wire  [1:0]         o_done_op;

    logic [ROWS-1:0]    life_cells [COLS];
    logic [tlg_pkg::CFG_W-1:0] width_reg = tlg_pkg::CFG_W'(tlg_pkg::DIM_RESET);
    logic [tlg_pkg::CFG_W-1:0] height_reg = tlg_pkg::CFG_W'(tlg_pkg::DIM_RESET);
    t_board_result      awaited [$];
    t_script_row        script [SCRIPT_LEN];
    int                 fail_count = 0;
    int                 send_gap_pct = 0;
    int                 stall_pct = 0;
    int                 cycles = 0;

    toroidal_life_grid_engine #(
        .MAX_COLS(COLS),
        .MAX_ROWS(ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (in_func),
        .i_col        (in_col),
        .i_row        (in_row),
        .i_cell_value (in_val),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_read_value (o_read_value),
        .o_done_op    (o_done_op),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int active_cols();
        int w;
        w = width_reg;
        if (w < tlg_pkg::DIM_MIN) w = tlg_pkg::DIM_MIN;
        if (w > COLS) w = COLS;
        return w;
    endfunction

    function automatic int active_rows();
        int h;
        h = height_reg;
        if (h < tlg_pkg::DIM_MIN) h = tlg_pkg::DIM_MIN;
        if (h > ROWS) h = ROWS;
        return h;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    task automatic apply_request(input tlg_pkg::t_func op, input logic [5:0] col,
                                 input logic [5:0] row, input logic val, output logic rd);
        logic [ROWS-1:0] prev [COLS];
        int w, h, n, cc, rr;
        bit in_grid;
        w = active_cols();
        h = active_rows();
        in_grid = (col < w) && (row < h);
        rd = 1'b0;
        case (op)
            tlg_pkg::FUNC_WRITE: begin
                if (in_grid) life_cells[col][row] = val;
            end
            tlg_pkg::FUNC_READ: begin
                if (in_grid) rd = life_cells[col][row];
            end
            tlg_pkg::FUNC_CLEAR: begin
                foreach (life_cells[c]) life_cells[c] = '0;
            end
            default: begin
                prev = life_cells;
                for (int c = 0; c < w; c++) begin
                    for (int r = 0; r < h; r++) begin
                        n = 0;
                        for (int dc = -1; dc <= 1; dc++) begin
                            for (int dr = -1; dr <= 1; dr++) begin
                                if (dc != 0 || dr != 0) begin
                                    cc = (c + dc + w) % w;
                                    rr = (r + dr + h) % h;
                                    n += prev[cc][rr];
                                end
                            end
                        end
                        if (!prev[c][r]) begin
                            if (n == tlg_pkg::LIFE_BIRTH) life_cells[c][r] = 1'b1;
                        end else if (n != tlg_pkg::LIFE_SURVIVE && n != tlg_pkg::LIFE_BIRTH) begin
                            life_cells[c][r] = 1'b0;
                        end
                    end
                end
            end
        endcase
    endtask

    // enter and leave on a rising edge
    task automatic send_request(input tlg_pkg::t_func op, input logic [5:0] col,
                                input logic [5:0] row, input logic val, input logic typed,
                                input logic typed_rd);
        int gap;
        logic rd;
        t_board_result exp;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_func  <= op;
        in_col   <= col;
        in_row   <= row;
        in_val   <= val;
        do @(negedge i_clk); while (!o_in_ready);
        apply_request(op, col, row, val, rd);
        exp.rd = typed ? typed_rd : rd;
        exp.op = op;
        awaited.push_back(exp);
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [tlg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tlg_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == tlg_pkg::CFG_GRID_WIDTH) width_reg = data;
        else height_reg = data;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        t_board_result exp;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (awaited.size() == 0) begin
                note_failure($sformatf("unexpected result: read %0b op %0d",
                                       o_read_value, o_done_op));
            end else begin
                exp = awaited.pop_front();
                if (o_read_value !== exp.rd || o_done_op !== exp.op)
                    note_failure($sformatf("mismatch: expected read %0b op %0d, got read %0b op %0d",
                                           exp.rd, exp.op, o_read_value, o_done_op));
            end
        end
    end

    initial begin
        int wv, hv;
        tlg_pkg::t_func op;
        logic [5:0] c, r;
        int pick;

        foreach (life_cells[i]) life_cells[i] = '0;

        script[0]  = '{tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0};
        script[1]  = '{tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0};
        script[2]  = '{tlg_pkg::FUNC_WRITE, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0};
        script[3]  = '{tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b1};
        script[4]  = '{tlg_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0};
        script[5]  = '{tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b1};
        script[6]  = '{tlg_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b0, 1'b1, 1'b0};
        script[7]  = '{tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0};
        script[8]  = '{tlg_pkg::FUNC_CLEAR, 6'd17, 6'd42, 1'b1, 1'b1, 1'b0};
        script[9]  = '{tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0};
        // blinker across both wrap edges
        script[10] = '{tlg_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0};
        script[11] = '{tlg_pkg::FUNC_WRITE, 6'd0,  6'd63, 1'b1, 1'b0, 1'b0};
        script[12] = '{tlg_pkg::FUNC_WRITE, 6'd1,  6'd63, 1'b1, 1'b0, 1'b0};
        script[13] = '{tlg_pkg::FUNC_STEP,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0};
        script[14] = '{tlg_pkg::FUNC_READ,  6'd0,  6'd62, 1'b0, 1'b0, 1'b0};
        script[15] = '{tlg_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0};
        script[16] = '{tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0};
        script[17] = '{tlg_pkg::FUNC_STEP,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0};
        script[18] = '{tlg_pkg::FUNC_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0};
        script[19] = '{tlg_pkg::FUNC_READ,  6'd1,  6'd63, 1'b1, 1'b0, 1'b0};
        script[20] = '{tlg_pkg::FUNC_WRITE, 6'd5,  6'd5,  1'b0, 1'b1, 1'b0};
        script[21] = '{tlg_pkg::FUNC_CLEAR, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_request(script[i].op, script[i].col, script[i].row, script[i].val,
                         script[i].typed, script[i].rd);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin wv = 127; hv = 127; end
                1: begin wv = 3;   hv = 3;   end
                2: begin wv = 0;   hv = 0;   end
                3: begin wv = 64;  hv = 3;   end
                4: begin wv = 3;   hv = 64;  end
                5: begin wv = $urandom_range(3, 64); hv = $urandom_range(3, 64); end
                6: begin wv = $urandom_range(127);   hv = $urandom_range(127);   end
                default: begin wv = 64; hv = 64; end
            endcase
            write_register(tlg_pkg::CFG_GRID_WIDTH, tlg_pkg::CFG_W'(wv));
            write_register(tlg_pkg::CFG_GRID_HEIGHT, tlg_pkg::CFG_W'(hv));
            cfg_we <= 1'b0;

            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 51; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 51; end
                default: begin send_gap_pct = 13; stall_pct = 13; end
            endcase

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 45) op = tlg_pkg::FUNC_WRITE;
                else if (pick < 80) op = tlg_pkg::FUNC_READ;
                else if (pick < 83) op = tlg_pkg::FUNC_CLEAR;
                else op = tlg_pkg::FUNC_STEP;
                // mostly inside the active grid so patterns form
                if ($urandom_range(99) < 85) c = 6'($urandom_range(active_cols() - 1));
                else c = 6'($urandom_range(63));
                if ($urandom_range(99) < 85) r = 6'($urandom_range(active_rows() - 1));
                else r = 6'($urandom_range(63));
                send_request(op, c, r, ($urandom_range(99) < 60), 1'b0, 1'b0);
            end
            drain_results();
        end

        if (fail_count == 0 && awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
